// ----- sv/fbab_pkg.sv -----
// Shared types, constants and codes for the framebuffer alpha blend pixel unit.
package fbab_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 32;
    localparam int CFG_W       = 7;
    localparam int MUL_W       = 8;
    localparam int ACC_W       = 2 * MUL_W;
    localparam int CH_W        = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [1:0] CMD_BLEND = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 7'd64;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 7'd64;

    localparam logic [CH_W-1:0] FULL_ALPHA = 8'd255;
    localparam logic [1:0]      LAST_CH    = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [PIX_W-1:0]  pixel_color;
    } t_item;

    typedef struct packed {
        logic             in_range;
        logic [PIX_W-1:0] pixel_value;
    } t_result;

    typedef struct packed {
        logic             load;
        logic             accum;
        logic [MUL_W-1:0] op_a;
        logic [MUL_W-1:0] op_b;
    } t_mac_ctl;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } t_ram_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_CALC,
        S_RD,
        S_RDW,
        S_MULF,
        S_MULB,
        S_QUO,
        S_WR,
        S_OUT
    } t_state;

endpackage

// ----- sv/fbab_ram.sv -----
// Generic single-port RAM with registered read.
module fbab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fbab_mac.sv -----
// Shared 8x8 multiply-accumulate unit with divide-by-255 output.
module fbab_mac (
    input  logic                       i_clk,
    input  fbab_pkg::t_mac_ctl         i_ctl,
    output logic [fbab_pkg::ACC_W-1:0] o_acc,
    output logic [fbab_pkg::CH_W-1:0]  o_quot
);

    logic [fbab_pkg::ACC_W-1:0] r_acc;
    logic [fbab_pkg::ACC_W-1:0] prod;
    logic [fbab_pkg::ACC_W:0]   div_sum;

    assign prod = fbab_pkg::ACC_W'(i_ctl.op_a) * fbab_pkg::ACC_W'(i_ctl.op_b);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= prod;
        end else if (i_ctl.accum) begin
            r_acc <= r_acc + prod;
        end
    end

    // exact v/255 for v below 65280
    assign div_sum = {1'b0, r_acc} + (fbab_pkg::ACC_W + 1)'(1)
                   + (fbab_pkg::ACC_W + 1)'(r_acc >> 8);
    assign o_quot  = div_sum[fbab_pkg::ACC_W-1:8];
    assign o_acc   = r_acc;

endmodule

// ----- sv/fbab_seq.sv -----
// Sequencer: range check, address, blend passes and store access.
module fbab_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  fbab_pkg::t_item              i_item,
    input  logic [fbab_pkg::CFG_W-1:0]   i_width,
    input  logic [fbab_pkg::CFG_W-1:0]   i_height,
    input  logic [fbab_pkg::ACC_W-1:0]   i_acc,
    input  logic [fbab_pkg::CH_W-1:0]    i_quot,
    input  logic [fbab_pkg::PIX_W-1:0]   i_rdata,
    output logic                         o_busy,
    output logic                         o_done,
    output fbab_pkg::t_result            o_result,
    output fbab_pkg::t_mac_ctl           o_mac,
    output fbab_pkg::t_ram_req           o_ram
);

    fbab_pkg::t_state                r_state, n_state;
    logic [1:0]                      r_cmd, n_cmd;
    logic [fbab_pkg::CFG_W-1:0]      r_x, n_x;
    logic [fbab_pkg::CFG_W-1:0]      r_y, n_y;
    logic [fbab_pkg::PIX_W-1:0]      r_color, n_color;
    logic                            r_in_range, n_in_range;
    logic [fbab_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [fbab_pkg::PIX_W-1:0]      r_pix, n_pix;
    logic [1:0]                      r_ch, n_ch;
    logic                            inr;
    logic [1:0]                      lane;

    assign inr = !i_item.x_coord[15] && !i_item.y_coord[15]
              && (i_item.x_coord[14:0] < 15'(i_width))
              && (i_item.y_coord[14:0] < 15'(i_height));

    // channel 0 is red in the top byte
    assign lane = 2'd3 - r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbab_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd      <= n_cmd;
        r_x        <= n_x;
        r_y        <= n_y;
        r_color    <= n_color;
        r_in_range <= n_in_range;
        r_addr     <= n_addr;
        r_pix      <= n_pix;
        r_ch       <= n_ch;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_x        = r_x;
        n_y        = r_y;
        n_color    = r_color;
        n_in_range = r_in_range;
        n_addr     = r_addr;
        n_pix      = r_pix;
        n_ch       = r_ch;
        o_mac      = '0;
        o_ram      = '0;
        o_ram.addr = r_addr;
        o_ram.wdata = r_pix;
        o_done     = 1'b0;
        unique case (r_state)
            fbab_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd      = i_item.cmd;
                    n_x        = i_item.x_coord[fbab_pkg::CFG_W-1:0];
                    n_y        = i_item.y_coord[fbab_pkg::CFG_W-1:0];
                    n_color    = i_item.pixel_color;
                    n_in_range = inr;
                    if (inr) begin
                        n_state = fbab_pkg::S_ADDR;
                    end else begin
                        n_pix   = '0;
                        n_state = fbab_pkg::S_OUT;
                    end
                end
            end
            fbab_pkg::S_ADDR: begin
                o_mac.load = 1'b1;
                o_mac.op_a = fbab_pkg::MUL_W'(r_y);
                o_mac.op_b = fbab_pkg::MUL_W'(i_width);
                n_state    = fbab_pkg::S_CALC;
            end
            fbab_pkg::S_CALC: begin
                n_addr = fbab_pkg::ADDR_W'(i_acc) + fbab_pkg::ADDR_W'(r_x);
                if (r_cmd == fbab_pkg::CMD_WRITE) begin
                    n_pix   = r_color;
                    n_state = fbab_pkg::S_WR;
                end else begin
                    n_state = fbab_pkg::S_RD;
                end
            end
            fbab_pkg::S_RD: begin
                o_ram.re = 1'b1;
                n_state  = fbab_pkg::S_RDW;
            end
            fbab_pkg::S_RDW: begin
                n_pix = i_rdata;
                n_ch  = '0;
                if (r_cmd == fbab_pkg::CMD_BLEND) begin
                    n_state = fbab_pkg::S_MULF;
                end else begin
                    n_state = fbab_pkg::S_OUT;
                end
            end
            fbab_pkg::S_MULF: begin
                o_mac.load = 1'b1;
                o_mac.op_a = r_color[fbab_pkg::CH_W-1:0];
                o_mac.op_b = r_color[{lane, 3'b000} +: fbab_pkg::CH_W];
                n_state    = fbab_pkg::S_MULB;
            end
            fbab_pkg::S_MULB: begin
                o_mac.accum = 1'b1;
                o_mac.op_a  = fbab_pkg::FULL_ALPHA - r_color[fbab_pkg::CH_W-1:0];
                o_mac.op_b  = r_pix[{lane, 3'b000} +: fbab_pkg::CH_W];
                n_state     = fbab_pkg::S_QUO;
            end
            fbab_pkg::S_QUO: begin
                n_pix[{lane, 3'b000} +: fbab_pkg::CH_W] = i_quot;
                if (r_ch == fbab_pkg::LAST_CH) begin
                    n_pix[fbab_pkg::CH_W-1:0] = fbab_pkg::FULL_ALPHA;
                    n_state = fbab_pkg::S_WR;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = fbab_pkg::S_MULF;
                end
            end
            fbab_pkg::S_WR: begin
                o_ram.we = 1'b1;
                n_state  = fbab_pkg::S_OUT;
            end
            fbab_pkg::S_OUT: begin
                o_done  = 1'b1;
                n_state = fbab_pkg::S_IDLE;
            end
            default: begin
                n_state = fbab_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy               = (r_state != fbab_pkg::S_IDLE);
    assign o_result.in_range    = r_in_range;
    assign o_result.pixel_value = r_pix;

`ifndef SYNTH
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe lasted more than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transfer did not raise busy");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.in_range) |-> (o_result.pixel_value == '0))
        else $error("out-of-range result carries nonzero pixel");

    a_blend_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.in_range && r_cmd == fbab_pkg::CMD_BLEND)
        |-> (o_result.pixel_value[fbab_pkg::CH_W-1:0] == fbab_pkg::FULL_ALPHA))
        else $error("blended pixel alpha not forced opaque");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_in_range && $past(o_busy)))
        else $error("store written for out-of-range access");
`endif

endmodule

// ----- sv/framebuffer_alpha_blend_pixel.sv -----
// Top level of the RGBA8888 framebuffer pixel unit with alpha blending.
//   channel  | handshake                 | payload
//   item     | i_start / o_busy          | i_item   (cmd, x_coord, y_coord, pixel_color)
//   result   | o_done strobe, one cycle  | o_result (in_range, pixel_value)
//   config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// Busy drops in the cycle after o_done. Blend time is set by one shared 8x8
// multiplier (address plus two passes per color channel) and the single-port store.
// Reset restores width and height 64; store contents stay undefined until written.
// The receiver cannot stall: o_done marks each result for one cycle only.
module framebuffer_alpha_blend_pixel (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  fbab_pkg::t_item                  i_item,
    output logic                             o_done,
    output fbab_pkg::t_result                o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fbab_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbab_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [fbab_pkg::CFG_W-1:0]  r_width, n_width;
    logic [fbab_pkg::CFG_W-1:0]  r_height, n_height;
    logic [fbab_pkg::CFG_W-1:0]  width_eff;
    logic [fbab_pkg::CFG_W-1:0]  height_eff;
    logic [fbab_pkg::ACC_W-1:0]  acc;
    logic [fbab_pkg::CH_W-1:0]   quot;
    logic [fbab_pkg::PIX_W-1:0]  rdata;
    fbab_pkg::t_mac_ctl          mac_ctl;
    fbab_pkg::t_ram_req          ram_req;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fbab_pkg::CFG_IMAGE_WIDTH:  n_width  = i_cfg_data;
                fbab_pkg::CFG_IMAGE_HEIGHT: n_height = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= fbab_pkg::RST_WIDTH;
            r_height <= fbab_pkg::RST_HEIGHT;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign width_eff  = (int'(r_width) > fbab_pkg::MAX_WIDTH)
                      ? fbab_pkg::CFG_W'(fbab_pkg::MAX_WIDTH) : r_width;
    assign height_eff = (int'(r_height) > fbab_pkg::MAX_HEIGHT)
                      ? fbab_pkg::CFG_W'(fbab_pkg::MAX_HEIGHT) : r_height;

    fbab_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .i_width  (width_eff),
        .i_height (height_eff),
        .i_acc    (acc),
        .i_quot   (quot),
        .i_rdata  (rdata),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_mac    (mac_ctl),
        .o_ram    (ram_req)
    );

    fbab_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .o_acc  (acc),
        .o_quot (quot)
    );

    fbab_ram #(
        .WIDTH (fbab_pkg::PIX_W),
        .DEPTH (fbab_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_re    (ram_req.re),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (rdata)
    );

endmodule
